// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mcct_pkg.sv -----
// Package: codes, widths and the memory request type of the countdown timer bank.
`timescale 1ns / 1ps
package mcct_pkg;

	localparam int OP_W    = 3;
	localparam int SLOT_W  = 4;
	localparam int CNT_W   = 31;
	localparam int STAT_W  = 2;

	localparam int SLOTS_DEF = 16;
	localparam int SLOTS_MAX = 16;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_START  = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFREE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTALLOC = 2'd2;

	typedef struct packed {
		logic              cd_re;
		logic [SLOT_W-1:0] cd_raddr;
		logic              cd_we;
		logic [SLOT_W-1:0] cd_waddr;
		logic [CNT_W-1:0]  cd_wdata;
		logic              rl_re;
		logic [SLOT_W-1:0] rl_raddr;
		logic              rl_we;
		logic [SLOT_W-1:0] rl_waddr;
		logic [CNT_W-1:0]  rl_wdata;
	} mem_req_t;

endpackage

// ----- rtl/mcct_if.sv -----
// Interfaces: command and response channels of the countdown timer bank.
`timescale 1ns / 1ps
interface mcct_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [mcct_pkg::OP_W-1:0]  operation;
	logic [mcct_pkg::SLOT_W-1:0] slot_index;
	logic [mcct_pkg::CNT_W-1:0] count_value;

	modport source (output valid, output operation, output slot_index, output count_value,
		input ready);
	modport sink (input valid, input operation, input slot_index, input count_value,
		output ready);
endinterface

interface mcct_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mcct_pkg::STAT_W-1:0]  status;
	logic [mcct_pkg::SLOT_W-1:0]  result_slot;
	logic                         expired;
	logic                         last;

	modport source (output valid, output status, output result_slot, output expired,
		output last, input ready);
	modport sink (input valid, input status, input result_slot, input expired,
		input last, output ready);
endinterface

// ----- rtl/mcct_store.sv -----
// Slot memories: countdown and reload count, one write and one registered read each.
`timescale 1ns / 1ps
module mcct_store #(
	parameter int NSLOT = mcct_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  mcct_pkg::mem_req_t         mem,
	output logic [mcct_pkg::CNT_W-1:0] cd_rdata,
	output logic [mcct_pkg::CNT_W-1:0] rl_rdata
);
	localparam int IW = (NSLOT > 1) ? $clog2(NSLOT) : 1;

	logic [mcct_pkg::CNT_W-1:0] cd_mem [NSLOT];
	logic [mcct_pkg::CNT_W-1:0] rl_mem [NSLOT];

	always_ff @(posedge clk) begin
		if (mem.cd_we) begin
			cd_mem[mem.cd_waddr[IW-1:0]] <= mem.cd_wdata;
		end
		if (mem.cd_re) begin
			cd_rdata <= cd_mem[mem.cd_raddr[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mem.rl_we) begin
			rl_mem[mem.rl_waddr[IW-1:0]] <= mem.rl_wdata;
		end
		if (mem.rl_re) begin
			rl_rdata <= rl_mem[mem.rl_raddr[IW-1:0]];
		end
	end

endmodule

// ----- rtl/mcct_ctrl.sv -----
// Controller: slot flags, command execution, tick walk and response register.
`timescale 1ns / 1ps
module mcct_ctrl #(
	parameter int NSLOT = mcct_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mcct_cmd_if.sink                   cmd,
	mcct_rsp_if.source                 rsp,
	output mcct_pkg::mem_req_t         mem,
	input  logic [mcct_pkg::CNT_W-1:0] cd_rdata,
	input  logic [mcct_pkg::CNT_W-1:0] rl_rdata
);
	localparam int IW  = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int CW  = $clog2(NSLOT + 1);
	localparam int SW1 = mcct_pkg::SLOT_W + 1;
	localparam logic [CW-1:0] WALK_END = CW'(NSLOT);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]                    state_q;
	logic [mcct_pkg::OP_W-1:0]     op_q;
	logic [mcct_pkg::SLOT_W-1:0]   slot_q;
	logic [mcct_pkg::CNT_W-1:0]    cnt_q;
	logic [NSLOT-1:0]              alloc_q;
	logic [NSLOT-1:0]              run_q;
	logic [NSLOT-1:0]              pdel_q;
	logic [CW-1:0]                 rd_idx_q;
	logic                          v_s1;
	logic [IW-1:0]                 idx_s1;
	logic                          hold_v_q;
	logic [IW-1:0]                 hold_slot_q;
	logic                          rsp_v_q;
	logic [mcct_pkg::STAT_W-1:0]   rsp_status_q;
	logic [mcct_pkg::SLOT_W-1:0]   rsp_slot_q;
	logic                          rsp_exp_q;
	logic                          rsp_last_q;

	logic                          accept;
	logic                          can_push;
	logic                          free_found;
	logic [IW-1:0]                 free_idx;
	logic [IW-1:0]                 sidx;
	logic                          slot_ok;
	logic                          eval_act;
	logic                          eval_exp;
	logic                          walk_push;
	logic                          advance;
	logic                          issue;
	logic                          exec_go;
	logic                          fin_go;
	logic                          push;
	logic [mcct_pkg::STAT_W-1:0]   exec_status;
	logic [mcct_pkg::SLOT_W-1:0]   exec_slot;
	logic [mcct_pkg::STAT_W-1:0]   nxt_status;
	logic [mcct_pkg::SLOT_W-1:0]   nxt_slot;
	logic                          nxt_exp;
	logic                          nxt_last;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign can_push  = !rsp_v_q || rsp.ready;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (!alloc_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign sidx    = slot_q[IW-1:0];
	assign slot_ok = (SW1'(slot_q) < SW1'(NSLOT)) && alloc_q[sidx];

	// walk stage 1: countdown word of slot idx_s1 is on cd_rdata
	assign eval_act  = v_s1 && alloc_q[idx_s1] && run_q[idx_s1] && (cd_rdata != '0);
	assign eval_exp  = eval_act && (cd_rdata == mcct_pkg::CNT_W'(1));
	assign walk_push = eval_exp && hold_v_q;
	assign advance   = !walk_push || can_push;
	assign issue     = (state_q == S_WALK) && (rd_idx_q != WALK_END) && advance;
	assign exec_go   = (state_q == S_EXEC) && can_push;
	assign fin_go    = (state_q == S_FIN) && can_push;
	assign push      = exec_go || (walk_push && can_push) || fin_go;

	always_comb begin
		unique case (op_q)
			mcct_pkg::OP_CREATE: begin
				exec_status = free_found ? mcct_pkg::STAT_OK : mcct_pkg::STAT_NOFREE;
				exec_slot   = free_found ? mcct_pkg::SLOT_W'(free_idx) : '0;
			end
			mcct_pkg::OP_DELETE, mcct_pkg::OP_START, mcct_pkg::OP_STOP: begin
				exec_status = slot_ok ? mcct_pkg::STAT_OK : mcct_pkg::STAT_NOTALLOC;
				exec_slot   = slot_q;
			end
			default: begin
				exec_status = mcct_pkg::STAT_OK;
				exec_slot   = slot_q;
			end
		endcase
	end

	always_comb begin
		priority if (state_q == S_EXEC) begin
			nxt_status = exec_status;
			nxt_slot   = exec_slot;
			nxt_exp    = 1'b0;
			nxt_last   = 1'b1;
		end else if (state_q == S_WALK) begin
			nxt_status = mcct_pkg::STAT_OK;
			nxt_slot   = mcct_pkg::SLOT_W'(hold_slot_q);
			nxt_exp    = 1'b1;
			nxt_last   = 1'b0;
		end else begin
			nxt_status = mcct_pkg::STAT_OK;
			nxt_slot   = hold_v_q ? mcct_pkg::SLOT_W'(hold_slot_q) : '0;
			nxt_exp    = hold_v_q;
			nxt_last   = 1'b1;
		end
	end

	// memory requests
	always_comb begin
		mem.cd_re    = issue;
		mem.cd_raddr = mcct_pkg::SLOT_W'(rd_idx_q[IW-1:0]);
		mem.cd_we    = (eval_act && advance)
			|| (exec_go && (op_q == mcct_pkg::OP_START) && slot_ok);
		if (state_q == S_EXEC) begin
			mem.cd_waddr = slot_q;
			mem.cd_wdata = (cnt_q != '0) ? cnt_q : rl_rdata;
		end else begin
			mem.cd_waddr = mcct_pkg::SLOT_W'(idx_s1);
			mem.cd_wdata = cd_rdata - mcct_pkg::CNT_W'(1);
		end
		mem.rl_re    = accept;
		mem.rl_raddr = cmd.slot_index;
		mem.rl_we    = exec_go && (op_q == mcct_pkg::OP_CREATE) && free_found;
		mem.rl_waddr = mcct_pkg::SLOT_W'(free_idx);
		mem.rl_wdata = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			alloc_q  <= '0;
			run_q    <= '0;
			pdel_q   <= '0;
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
			hold_v_q <= 1'b0;
			rsp_v_q  <= 1'b0;
		end else begin
			if (push) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.operation == mcct_pkg::OP_TICK) begin
							// free the slots marked for delete
							alloc_q  <= alloc_q & ~pdel_q;
							run_q    <= run_q & ~pdel_q;
							pdel_q   <= '0;
							rd_idx_q <= '0;
							v_s1     <= 1'b0;
							hold_v_q <= 1'b0;
							state_q  <= S_WALK;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if (can_push) begin
						unique case (op_q)
							mcct_pkg::OP_CREATE: begin
								if (free_found) begin
									alloc_q[free_idx] <= 1'b1;
									run_q[free_idx]   <= 1'b0;
									pdel_q[free_idx]  <= 1'b0;
								end
							end
							mcct_pkg::OP_DELETE: begin
								if (slot_ok) begin
									run_q[sidx]  <= 1'b0;
									pdel_q[sidx] <= 1'b1;
								end
							end
							mcct_pkg::OP_START: begin
								if (slot_ok) begin
									run_q[sidx] <= 1'b1;
								end
							end
							mcct_pkg::OP_STOP: begin
								if (slot_ok) begin
									run_q[sidx] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
						state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					if (advance) begin
						v_s1 <= issue;
						if (issue) begin
							rd_idx_q <= rd_idx_q + CW'(1);
						end
						if (eval_exp) begin
							hold_v_q <= 1'b1;
						end
					end
					if ((rd_idx_q == WALK_END) && !v_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (can_push) begin
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.operation;
			slot_q <= cmd.slot_index;
			cnt_q  <= cmd.count_value;
		end
		if ((state_q == S_WALK) && advance) begin
			idx_s1 <= rd_idx_q[IW-1:0];
			if (eval_exp) begin
				hold_slot_q <= idx_s1;
			end
		end
		if (push) begin
			rsp_status_q <= nxt_status;
			rsp_slot_q   <= nxt_slot;
			rsp_exp_q    <= nxt_exp;
			rsp_last_q   <= nxt_last;
		end
	end

	assign rsp.valid       = rsp_v_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.result_slot = rsp_slot_q;
	assign rsp.expired     = rsp_exp_q;
	assign rsp.last        = rsp_last_q;

endmodule

// ----- rtl/multi_channel_countdown_timers.sv -----
// Top level: bank of countdown timers held in slot memories.
`timescale 1ns / 1ps
// A bank of up to sixteen countdown timers. Each command word on cmd is one of
// create, delete, start, stop or tick; each response word on rsp carries a status,
// a slot number, an expired flag and a last flag that closes the command's
// responses. Create, delete, start and stop give exactly one response. A tick
// first frees every slot whose delete is pending, then walks the slots in order,
// decrements each running, allocated slot above zero and reports each that hits
// zero; with no expiry it gives a single response on slot 0 with expired low.
// cmd.ready is high only between commands. A non-tick command reads the reload
// memory on acceptance, then executes and loads the response register. A tick
// walks the slots through the countdown memory's read port, one slot a cycle
// while the response register can take the next expiry, with the write-back of
// the slot before it on the separate write port. A response register decouples
// rsp; while it is not taken the walk holds on the next expiry, so a slow sink
// stretches the tick. Slot flags sit in flops cleared by arst_n; the countdown
// and reload memories need no clearing pass.
module multi_channel_countdown_timers #(
	parameter int SLOTS = mcct_pkg::SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mcct_cmd_if.sink   cmd,
	mcct_rsp_if.source rsp
);
	// slot fields are 4 bits wide, so at most sixteen slots exist
	localparam int NSLOT = (SLOTS < mcct_pkg::SLOTS_MAX) ? SLOTS : mcct_pkg::SLOTS_MAX;

	mcct_pkg::mem_req_t         mem;
	logic [mcct_pkg::CNT_W-1:0] cd_rdata;
	logic [mcct_pkg::CNT_W-1:0] rl_rdata;

	// flags, command sequencing, tick walk and response register
	mcct_ctrl #(
		.NSLOT (NSLOT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rsp      (rsp),
		.mem      (mem),
		.cd_rdata (cd_rdata),
		.rl_rdata (rl_rdata)
	);

	// countdown and reload memories
	mcct_store #(
		.NSLOT (NSLOT)
	) u_store (
		.clk      (clk),
		.mem      (mem),
		.cd_rdata (cd_rdata),
		.rl_rdata (rl_rdata)
	);

endmodule

// ----- rtl/mcct_checker.sv -----
// Port checker for the countdown timer bank, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcct_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [mcct_pkg::STAT_W-1:0] rsp_status,
	input logic [mcct_pkg::SLOT_W-1:0] rsp_slot,
	input logic                        rsp_expired,
	input logic                        rsp_last
);
	// a held word does not change
	`ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_expired) && $stable(rsp_last), "response word changed while stalled")
	// expiry reports are always ok
	`ASSERT_IMPL(a_exp_ok, rsp_valid && rsp_expired, rsp_status == mcct_pkg::STAT_OK, "expiry with error status")
	// a full bank answers on slot 0
	`ASSERT_IMPL(a_nofree_slot, rsp_valid && (rsp_status == mcct_pkg::STAT_NOFREE), (rsp_slot == '0) && rsp_last && !rsp_expired, "bad no-free response")
	// no command is taken in the cycle after one was taken
	`ASSERT_NEXT(a_cmd_gap, cmd_valid && cmd_ready, !cmd_ready, "command accepted back to back")
endmodule

bind multi_channel_countdown_timers mcct_checker u_mcct_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_slot    (rsp.result_slot),
	.rsp_expired (rsp.expired),
	.rsp_last    (rsp.last)
);
